FILE: rtl/core/tdq_pkg.sv
`timescale 1ns / 1ps

package tdq_pkg;

	localparam logic REG_FLAT_TOL = 1'b0;
	localparam logic REG_COS_MIN  = 1'b1;

	localparam logic [15:0] FLAT_TOL_RESET = 16'd1;
	localparam logic [15:0] COS_MIN_RESET  = 16'd31164;

	// Squared reset values, kept beside the registers.
	localparam logic [31:0] FLAT_TOL_SQ_RESET = 32'd1;
	localparam logic [30:0] COS_MIN_SQ_RESET  = 31'd971194896;

	// Q1.15 unit shifted into the squared domain: (2^15)^2.
	localparam int COS_SQ_SHIFT = 30;

	// Face pairs for the dihedral tests.
	localparam int NUM_PAIRS = 6;
	localparam int PAIR_I [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_J [NUM_PAIRS] = '{1, 2, 3, 2, 3, 3};

endpackage

FILE: rtl/core/tetra_dihedral_quality_test.sv
`timescale 1ns / 1ps

// From an accepted input request, the data passes through the pipeline stages and
// then the output register to m_tvalid. The wide squares and products are
// split into partial products in one stage and summed in the next.
// Throughput: one tetrahedron per cycle; the pipeline advances whenever the
// output register is empty or is taken, so a stalled output holds every stage.
// Reset (arst_n low, asynchronous) clears all valid bits and sets
// flat_tolerance to 1 and cos_min_angle to 31164.
module tetra_dihedral_quality_test #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz from bit 0 up, zero pad
	input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// well_conditioned at bit 0, zero pad
	output logic [7:0] m_tdata,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int D  = COORD_BITS + 1;      // edge difference
	localparam int N  = 2 * D + 1;           // normal component
	localparam int S  = D + N + 2;           // distance numerator
	localparam int NN = 2 * N + 2;           // squared normal / normal dot
	localparam int M  = 2 * NN;              // product of two NN values
	localparam int CW = M + tdq_pkg::COS_SQ_SHIFT + 1;
	localparam int SL = (S + 1) / 2;         // low half of |s|
	localparam int SU = S - SL;              // high half of |s|
	localparam int NH = NN / 2;              // limb of an NN or M value
	localparam int FR = NH + 32;             // tolerance square times a limb
	localparam int RP = NH + 31;             // cosine square times a limb

	// Configuration: squared copies and the sign of the cosine.
	logic cos_neg_q;
	logic [31:0] tol_sq_q;
	logic [30:0] cos_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_neg_q <= tdq_pkg::COS_MIN_RESET[15];
			tol_sq_q  <= tdq_pkg::FLAT_TOL_SQ_RESET;
			cos_sq_q  <= tdq_pkg::COS_MIN_SQ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdq_pkg::REG_FLAT_TOL: begin
					tol_sq_q <= 32'(cfg_data) * 32'(cfg_data);
				end
				tdq_pkg::REG_COS_MIN: begin
					cos_neg_q <= cfg_data[15];
					cos_sq_q  <= 31'($signed(32'(signed'(cfg_data))) *
					                 $signed(32'(signed'(cfg_data))));
				end
				default: begin
				end
			endcase
		end
	end

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// Vertex coordinates.
	logic signed [COORD_BITS-1:0] p [4][3];
	always_comb begin
		for (int v = 0; v < 4; v++)
			for (int k = 0; k < 3; k++)
				p[v][k] = s_tdata[(v*3+k)*COORD_BITS +: COORD_BITS];
	end

	// Face f: base, e1, e2, opposite vertex.
	localparam int FB [4] = '{0, 0, 0, 1};
	localparam int F1 [4] = '{1, 1, 2, 2};
	localparam int F2 [4] = '{2, 3, 3, 3};
	localparam int FO [4] = '{3, 2, 1, 0};

	logic [10:0] vld;

	// Stage 1: edge vectors.
	logic signed [D-1:0] u_s1 [4][3], v_s1 [4][3], w_s1 [4][3];
	// Stage 2: cross-product terms.
	logic signed [2*D-1:0] xa_s2 [4][3], xb_s2 [4][3];
	logic signed [D-1:0] w_s2 [4][3];
	// Stage 3: normals.
	logic signed [N-1:0] n_s3 [4][3];
	logic signed [D-1:0] w_s3 [4][3];
	// Stage 4: products for distance and squared length.
	logic signed [D+N-1:0] wn_s4 [4][3];
	logic [2*N-1:0] nsq_s4 [4][3];
	logic signed [N-1:0] n_s4 [4][3];
	// Stage 5: distance numerator and squared length.
	logic signed [S-1:0] s_s5 [4];
	logic [NN-1:0] nn_s5 [4];
	logic signed [N-1:0] n_s5 [4][3];
	// Stage 6: partial products of the flatness test, pairwise normal products.
	logic [2*SL-1:0] ssl_s6 [4];
	logic [SL+SU-1:0] ssm_s6 [4];
	logic [2*SU-1:0] ssh_s6 [4];
	logic [FR-1:0] frl_s6 [4], frh_s6 [4];
	logic [3:0] szero_s6, spos_s6;
	logic signed [2*N-1:0] pp_s6 [tdq_pkg::NUM_PAIRS][3];
	logic [NN-1:0] nn_s6 [4];
	// Stage 7: both sides of the flatness test and the normal dots.
	logic [2*S-1:0] ssq_s7 [4];
	logic [NN+31:0] flat_rhs_s7 [4];
	logic [3:0] szero_s7, spos_s7;
	logic signed [NN-1:0] dn_s7 [tdq_pkg::NUM_PAIRS];
	logic [NN-1:0] nn_s7 [4];
	// Stage 8: flatness verdict and partial products of the angle test.
	logic flat_ok_s8;
	logic [tdq_pkg::NUM_PAIRS-1:0] ppos_s8, pzero_s8;
	logic [2*NH-1:0] dl_s8 [tdq_pkg::NUM_PAIRS], dm_s8 [tdq_pkg::NUM_PAIRS];
	logic [2*NH-1:0] dh_s8 [tdq_pkg::NUM_PAIRS];
	logic [2*NH-1:0] ml_s8 [tdq_pkg::NUM_PAIRS], mlh_s8 [tdq_pkg::NUM_PAIRS];
	logic [2*NH-1:0] mhl_s8 [tdq_pkg::NUM_PAIRS], mh_s8 [tdq_pkg::NUM_PAIRS];
	// Stage 9: squared dots and products of squared lengths.
	logic flat_ok_s9;
	logic [tdq_pkg::NUM_PAIRS-1:0] ppos_s9, pzero_s9;
	logic [M-1:0] dsq_s9 [tdq_pkg::NUM_PAIRS], mm_s9 [tdq_pkg::NUM_PAIRS];
	// Stage 10: scaled left side and partial products of the right side.
	logic flat_ok_s10;
	logic [tdq_pkg::NUM_PAIRS-1:0] ppos_s10, pzero_s10;
	logic [CW-1:0] lhs_s10 [tdq_pkg::NUM_PAIRS];
	logic [RP-1:0] rp_s10 [tdq_pkg::NUM_PAIRS][4];
	// Stage 11: both sides of the angle compare.
	logic flat_ok_s11;
	logic [tdq_pkg::NUM_PAIRS-1:0] ppos_s11, pzero_s11;
	logic [CW-1:0] lhs_s11 [tdq_pkg::NUM_PAIRS], rhs_s11 [tdq_pkg::NUM_PAIRS];

	// Magnitudes feeding the split squares.
	logic [S-1:0] smag [4];
	logic [NN-1:0] dmag [tdq_pkg::NUM_PAIRS];
	always_comb begin
		for (int f = 0; f < 4; f++)
			smag[f] = s_s5[f][S-1] ? $unsigned(-s_s5[f]) : $unsigned(s_s5[f]);
		for (int q = 0; q < tdq_pkg::NUM_PAIRS; q++)
			dmag[q] = dn_s7[q][NN-1] ? $unsigned(-dn_s7[q]) : $unsigned(dn_s7[q]);
	end

	logic flat_ok;
	always_comb begin
		flat_ok = 1'b1;
		for (int f = 0; f < 4; f++)
			if (szero_s7[f] || ((2*S+NN+32)'(ssq_s7[f]) < (2*S+NN+32)'(flat_rhs_s7[f])))
				flat_ok = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld <= '0;
		else if (en)
			vld <= {vld[9:0], s_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int f = 0; f < 4; f++) begin
				for (int k = 0; k < 3; k++) begin
					u_s1[f][k] <= D'(p[F1[f]][k]) - D'(p[FB[f]][k]);
					v_s1[f][k] <= D'(p[F2[f]][k]) - D'(p[FB[f]][k]);
					w_s1[f][k] <= D'(p[FO[f]][k]) - D'(p[FB[f]][k]);

					xa_s2[f][k] <= (2*D)'(u_s1[f][(k+1)%3]) * (2*D)'(v_s1[f][(k+2)%3]);
					xb_s2[f][k] <= (2*D)'(u_s1[f][(k+2)%3]) * (2*D)'(v_s1[f][(k+1)%3]);
					w_s2[f][k]  <= w_s1[f][k];

					n_s3[f][k] <= N'(xa_s2[f][k]) - N'(xb_s2[f][k]);
					w_s3[f][k] <= w_s2[f][k];

					wn_s4[f][k]  <= (D+N)'(w_s3[f][k]) * (D+N)'(n_s3[f][k]);
					nsq_s4[f][k] <= (2*N)'((2*N)'(n_s3[f][k]) * (2*N)'(n_s3[f][k]));
					n_s4[f][k]   <= n_s3[f][k];

					n_s5[f][k] <= n_s4[f][k];
				end
				s_s5[f]  <= S'(wn_s4[f][0]) + S'(wn_s4[f][1]) + S'(wn_s4[f][2]);
				nn_s5[f] <= NN'(nsq_s4[f][0]) + NN'(nsq_s4[f][1]) + NN'(nsq_s4[f][2]);

				ssl_s6[f]   <= (2*SL)'(smag[f][SL-1:0]) * (2*SL)'(smag[f][SL-1:0]);
				ssm_s6[f]   <= (SL+SU)'(smag[f][SL-1:0]) * (SL+SU)'(smag[f][S-1:SL]);
				ssh_s6[f]   <= (2*SU)'(smag[f][S-1:SL]) * (2*SU)'(smag[f][S-1:SL]);
				frl_s6[f]   <= FR'(tol_sq_q) * FR'(nn_s5[f][NH-1:0]);
				frh_s6[f]   <= FR'(tol_sq_q) * FR'(nn_s5[f][NN-1:NH]);
				szero_s6[f] <= (s_s5[f] == '0);
				spos_s6[f]  <= (s_s5[f] > 0);
				nn_s6[f]    <= nn_s5[f];

				ssq_s7[f]      <= (2*S)'(ssl_s6[f]) + ((2*S)'(ssm_s6[f]) << (SL + 1)) +
				                  ((2*S)'(ssh_s6[f]) << (2 * SL));
				flat_rhs_s7[f] <= (NN+32)'(frl_s6[f]) + ((NN+32)'(frh_s6[f]) << NH);
				nn_s7[f]       <= nn_s6[f];
			end
			szero_s7 <= szero_s6;
			spos_s7  <= spos_s6;

			for (int q = 0; q < tdq_pkg::NUM_PAIRS; q++) begin
				for (int k = 0; k < 3; k++)
					pp_s6[q][k] <= (2*N)'(n_s5[tdq_pkg::PAIR_I[q]][k]) *
					               (2*N)'(n_s5[tdq_pkg::PAIR_J[q]][k]);
				dn_s7[q] <= NN'(pp_s6[q][0]) + NN'(pp_s6[q][1]) + NN'(pp_s6[q][2]);

				// The negated dot of the outward normals is +dn when the two
				// faces orient differently, -dn when alike.
				pzero_s8[q] <= (dn_s7[q] == '0);
				ppos_s8[q]  <= (spos_s7[tdq_pkg::PAIR_I[q]] ^ spos_s7[tdq_pkg::PAIR_J[q]])
				               ? (dn_s7[q] > 0) : (dn_s7[q] < 0);
				dl_s8[q]  <= (2*NH)'(dmag[q][NH-1:0]) * (2*NH)'(dmag[q][NH-1:0]);
				dm_s8[q]  <= (2*NH)'(dmag[q][NH-1:0]) * (2*NH)'(dmag[q][NN-1:NH]);
				dh_s8[q]  <= (2*NH)'(dmag[q][NN-1:NH]) * (2*NH)'(dmag[q][NN-1:NH]);
				ml_s8[q]  <= (2*NH)'(nn_s7[tdq_pkg::PAIR_I[q]][NH-1:0]) *
				             (2*NH)'(nn_s7[tdq_pkg::PAIR_J[q]][NH-1:0]);
				mlh_s8[q] <= (2*NH)'(nn_s7[tdq_pkg::PAIR_I[q]][NH-1:0]) *
				             (2*NH)'(nn_s7[tdq_pkg::PAIR_J[q]][NN-1:NH]);
				mhl_s8[q] <= (2*NH)'(nn_s7[tdq_pkg::PAIR_I[q]][NN-1:NH]) *
				             (2*NH)'(nn_s7[tdq_pkg::PAIR_J[q]][NH-1:0]);
				mh_s8[q]  <= (2*NH)'(nn_s7[tdq_pkg::PAIR_I[q]][NN-1:NH]) *
				             (2*NH)'(nn_s7[tdq_pkg::PAIR_J[q]][NN-1:NH]);

				dsq_s9[q] <= M'(dl_s8[q]) + (M'(dm_s8[q]) << (NH + 1)) +
				             (M'(dh_s8[q]) << (2 * NH));
				mm_s9[q]  <= M'(ml_s8[q]) + ((M'(mlh_s8[q]) + M'(mhl_s8[q])) << NH) +
				             (M'(mh_s8[q]) << (2 * NH));

				lhs_s10[q] <= CW'(dsq_s9[q]) << tdq_pkg::COS_SQ_SHIFT;
				for (int l = 0; l < 4; l++)
					rp_s10[q][l] <= RP'(cos_sq_q) * RP'(mm_s9[q][l*NH +: NH]);

				lhs_s11[q] <= lhs_s10[q];
				rhs_s11[q] <= CW'(rp_s10[q][0]) + (CW'(rp_s10[q][1]) << NH) +
				              (CW'(rp_s10[q][2]) << (2 * NH)) +
				              (CW'(rp_s10[q][3]) << (3 * NH));
			end

			flat_ok_s8  <= flat_ok;
			flat_ok_s9  <= flat_ok_s8;
			ppos_s9     <= ppos_s8;
			pzero_s9    <= pzero_s8;
			flat_ok_s10 <= flat_ok_s9;
			ppos_s10    <= ppos_s9;
			pzero_s10   <= pzero_s9;
			flat_ok_s11 <= flat_ok_s10;
			ppos_s11    <= ppos_s10;
			pzero_s11   <= pzero_s10;
		end
	end

	logic angle_ok;
	always_comb begin
		angle_ok = 1'b1;
		for (int q = 0; q < tdq_pkg::NUM_PAIRS; q++) begin
			if (!cos_neg_q) begin
				if (ppos_s11[q] && (lhs_s11[q] > rhs_s11[q]))
					angle_ok = 1'b0;
			end else begin
				if (ppos_s11[q] || pzero_s11[q] || (lhs_s11[q] < rhs_s11[q]))
					angle_ok = 1'b0;
			end
		end
	end

	logic well_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (en)
			m_tvalid <= vld[10];
	end

	always_ff @(posedge clk) begin
		if (en)
			well_q <= flat_ok_s11 && angle_ok;
	end

	assign m_tdata = {7'b0, well_q};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(vld) && $stable(m_tdata)))
		else $error("pipeline moved during stall");

	a_last_stage_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[10] && s_tready) |=> m_tvalid)
		else $error("final stage request lost");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld[10] && s_tready) |=> !m_tvalid)
		else $error("result without request");

endmodule
